[hw/rtl/mrf_pkg.sv]
package mrf_pkg;

  // Request kinds as carried in the func field.
  typedef enum logic [1:0] {
    KIND_READ_COILS   = 2'd0,
    KIND_READ_HOLDING = 2'd1,
    KIND_WRITE_COILS  = 2'd2,
    KIND_WRITE_REGS   = 2'd3
  } kind_t;

  // Modbus function codes.
  localparam logic [7:0] FC_READ_COILS   = 8'h01;
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_WRITE_COILS  = 8'h0F;
  localparam logic [7:0] FC_WRITE_REGS   = 8'h10;

  localparam logic [15:0] MAX_WRITE_COILS = 16'd1968;
  localparam logic [15:0] MAX_WRITE_REGS  = 16'd123;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Data bytes one item can produce before the CRC: six header bytes,
  // the byte count and one register word.
  localparam int JOB_BYTES   = 9;
  localparam int JOB_CNT_W   = 4;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    kind_t       func;
    logic [7:0]  slave_address;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [15:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       rejected;
  } frame_t;

  // Work handed from the front to the back for one item.
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] data;
    logic [JOB_CNT_W-1:0]      count;
    logic                      finish;
    logic                      reject;
  } job_t;

  function automatic logic [7:0] kind_code(kind_t k);
    logic [7:0] code;
    case (k)
      KIND_READ_COILS:   code = FC_READ_COILS;
      KIND_READ_HOLDING: code = FC_READ_HOLDING;
      KIND_WRITE_COILS:  code = FC_WRITE_COILS;
      KIND_WRITE_REGS:   code = FC_WRITE_REGS;
      default:           code = FC_READ_COILS;
    endcase
    return code;
  endfunction

endpackage

[hw/rtl/mrf_front.sv]
// Request tracking: turns each accepted item into one job of data bytes.
module mrf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mrf_pkg::item_t item,
  output mrf_pkg::job_t  job
);

  logic                 in_request;
  mrf_pkg::kind_t       latched_kind;
  logic [15:0]          values_left;
  logic [7:0]           coil_shift;
  logic [2:0]           coil_bit_count;

  logic                 first;
  logic                 is_write;
  logic                 is_coil;
  logic                 reject;
  logic                 take;
  logic [7:0]           eff_shift;
  logic [2:0]           eff_cnt;
  logic [15:0]          eff_left;
  logic [15:0]          left_dec;
  logic [7:0]           new_shift;
  logic                 coil_emit;
  logic [7:0]           vb0;
  logic [7:0]           vb1;

  logic [mrf_pkg::JOB_CNT_W-1:0] vcnt;
  logic [16:0]                   coil_bytes;

  always_comb begin
    first     = !in_request;
    is_write  = item.func[1];
    reject    = first &&
                ((item.func == mrf_pkg::KIND_WRITE_COILS &&
                  item.quantity > mrf_pkg::MAX_WRITE_COILS) ||
                 (item.func == mrf_pkg::KIND_WRITE_REGS &&
                  item.quantity > mrf_pkg::MAX_WRITE_REGS));
    is_coil   = first ? (item.func == mrf_pkg::KIND_WRITE_COILS)
                      : (latched_kind == mrf_pkg::KIND_WRITE_COILS);
    eff_shift = first ? 8'd0 : coil_shift;
    eff_cnt   = first ? 3'd0 : coil_bit_count;
    eff_left  = first ? item.quantity : values_left;
    take      = !first || (is_write && item.quantity != 16'd0 && !reject);
    left_dec  = eff_left - 16'd1;
    new_shift = eff_shift | (8'(item.value != 16'd0) << eff_cnt);
    coil_emit = (eff_cnt == 3'd7) || (eff_left == 16'd1);

    if (is_coil) begin
      vb0  = new_shift;
      vb1  = 8'd0;
      vcnt = coil_emit ? mrf_pkg::JOB_CNT_W'(1) : mrf_pkg::JOB_CNT_W'(0);
    end else begin
      vb0  = item.value[15:8];
      vb1  = item.value[7:0];
      vcnt = mrf_pkg::JOB_CNT_W'(2);
    end

    coil_bytes = (17'(item.quantity) + 17'd7) >> 3;

    job = '0;
    if (reject) begin
      job.reject = 1'b1;
    end else if (first) begin
      job.data[0] = item.slave_address;
      job.data[1] = mrf_pkg::kind_code(item.func);
      job.data[2] = item.start_address[15:8];
      job.data[3] = item.start_address[7:0];
      job.data[4] = item.quantity[15:8];
      job.data[5] = item.quantity[7:0];
      if (!is_write) begin
        job.count  = mrf_pkg::JOB_CNT_W'(6);
        job.finish = 1'b1;
      end else begin
        job.data[6] = is_coil ? coil_bytes[7:0] : {item.quantity[6:0], 1'b0};
        job.data[7] = vb0;
        job.data[8] = vb1;
        job.count   = mrf_pkg::JOB_CNT_W'(7) + (take ? vcnt : mrf_pkg::JOB_CNT_W'(0));
        job.finish  = !take || (left_dec == 16'd0);
      end
    end else begin
      job.data[0] = vb0;
      job.data[1] = vb1;
      job.count   = vcnt;
      job.finish  = (left_dec == 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_request     <= 1'b0;
      latched_kind   <= mrf_pkg::KIND_READ_COILS;
      values_left    <= 16'd0;
      coil_shift     <= 8'd0;
      coil_bit_count <= 3'd0;
    end else if (push && take) begin
      if (first) begin
        latched_kind <= item.func;
      end
      if (left_dec == 16'd0) begin
        in_request     <= 1'b0;
        values_left    <= 16'd0;
        coil_shift     <= 8'd0;
        coil_bit_count <= 3'd0;
      end else begin
        in_request  <= 1'b1;
        values_left <= left_dec;
        if (is_coil && !coil_emit) begin
          coil_shift     <= new_shift;
          coil_bit_count <= eff_cnt + 3'd1;
        end else begin
          coil_shift     <= 8'd0;
          coil_bit_count <= 3'd0;
        end
      end
    end
  end

endmodule

[hw/rtl/mrf_job_fifo.sv]
// Short job queue between the front and the back.
module mrf_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mrf_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output mrf_pkg::job_t head_job
);

  mrf_pkg::job_t                  slots [mrf_pkg::FIFO_DEPTH];
  logic [mrf_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [mrf_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [mrf_pkg::FIFO_CNT_W-1:0] fill;

  assign full       = (fill == mrf_pkg::FIFO_CNT_W'(mrf_pkg::FIFO_DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == mrf_pkg::FIFO_PTR_W'(mrf_pkg::FIFO_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == mrf_pkg::FIFO_PTR_W'(mrf_pkg::FIFO_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      fill <= fill + mrf_pkg::FIFO_CNT_W'(push) - mrf_pkg::FIFO_CNT_W'(pop);
    end
  end

endmodule

[hw/rtl/mrf_back.sv]
// Byte sequencer: sends each job's bytes, runs the CRC and appends it.
module mrf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  mrf_pkg::job_t  job,
  output logic           pop,
  output logic           frame_valid,
  input  logic           frame_ready,
  output mrf_pkg::frame_t frame
);

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ mrf_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [15:0]                   crc_accum;
  logic [15:0]                   crc_accum_next;
  logic [mrf_pkg::JOB_CNT_W-1:0] pos;
  logic [mrf_pkg::JOB_CNT_W-1:0] total;
  logic                          slot_free;
  logic                          emit;
  mrf_pkg::frame_t               frame_next;

  always_comb begin
    total = job.count
          + (job.finish ? mrf_pkg::JOB_CNT_W'(2) : mrf_pkg::JOB_CNT_W'(0))
          + (job.reject ? mrf_pkg::JOB_CNT_W'(1) : mrf_pkg::JOB_CNT_W'(0));
    slot_free = !frame_valid || frame_ready;
    emit      = job_valid && (total != '0) && slot_free;
    pop       = job_valid && ((total == '0) || (slot_free && pos == total - 1'b1));

    crc_accum_next = crc_accum;
    frame_next     = '0;
    if (job.reject) begin
      frame_next.frame_end = 1'b1;
      frame_next.rejected  = 1'b1;
    end else if (pos < job.count) begin
      frame_next.tx_byte = job.data[pos];
      crc_accum_next     = crc_byte(crc_accum, job.data[pos]);
    end else if (pos == job.count) begin
      frame_next.tx_byte = crc_accum[7:0];
    end else begin
      frame_next.tx_byte   = crc_accum[15:8];
      frame_next.frame_end = 1'b1;
      crc_accum_next       = mrf_pkg::CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum   <= mrf_pkg::CRC_INIT;
      pos         <= '0;
      frame_valid <= 1'b0;
    end else begin
      if (emit) begin
        crc_accum <= crc_accum_next;
        pos       <= pop ? '0 : pos + 1'b1;
      end
      if (slot_free) begin
        frame_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame <= frame_next;
    end
  end

endmodule

[hw/rtl/modbus_rtu_request_framer.sv]
// Modbus RTU master request framer. Each accepted item transaction on the
// item channel is one step of a request: the first item of a request carries
// the kind (read coils, read holding registers, write multiple coils, write
// multiple registers), the slave, the start address and the quantity, and
// produces the header bytes (plus the byte count for writes). Reads end with
// that item. A write then takes one item per value (the first item already
// carries the first value); coils are packed eight to a byte with the first
// coil in bit 0, registers go out high byte first. Each frame closes with the
// CRC-16/MODBUS, low byte first, and frame_end marks its last byte. A write
// whose quantity exceeds 1968 coils or 123 registers produces a single result
// with rejected and frame_end set and tx_byte zero, and nothing else. The
// front half accepts an item whenever the two-entry job queue has room; the
// back half sends one byte per cycle on the frame channel while frame_ready
// lets it, an item produces up to eleven bytes (the first item of a register
// write), and an item that produces no byte (a coil that does not complete a
// byte) still passes through the back half, which retires its job. The back half
// is the limit on sustained rate; the front keeps accepting while a finished
// byte waits in the output register.
module modbus_rtu_request_framer (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  mrf_pkg::item_t  item,
  output logic            frame_valid,
  input  logic            frame_ready,
  output mrf_pkg::frame_t frame
);

  mrf_pkg::job_t front_job;
  mrf_pkg::job_t head_job;
  logic          push;
  logic          full;
  logic          pop;
  logic          head_valid;

  // An item transaction completes when the queue has room for its job.
  assign item_ready = !full;
  assign push       = item_valid && item_ready;

  mrf_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .item (item),
    .job  (front_job)
  );

  mrf_job_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (front_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  mrf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (head_valid),
    .job         (head_job),
    .pop         (pop),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  // A rejection result always closes its transaction group.
  a_reject_ends: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame.rejected |-> frame.frame_end && frame.tx_byte == 8'd0)
    else $error("rejection result without frame_end or with nonzero byte");

  // The back half only retires jobs that the queue actually holds.
  a_pop_has_job: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("job retired from an empty queue");

  // A byte left untaken must still be offered in the next cycle.
  a_hold_output: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |=> frame_valid && $stable(frame))
    else $error("output byte dropped or changed while stalled");

endmodule

[tb/sv/tb_modbus_rtu_request_framer.sv]
`timescale 1ns / 100ps

// Self-checking bench for the Modbus RTU request framer. Item transactions
// are driven on the falling edge with bursty gaps, and frame transactions are
// taken under a changing back-pressure pattern. A scoreboard rebuilds every
// request frame on its own, including the CRC, and compares each delivered
// byte against the oldest predicted one.
module tb_modbus_rtu_request_framer;
  import mrf_pkg::*;

  // Bytes of one frame as the block should deliver them, in order. The
  // scoreboard keeps its own copy of the framer state: the running CRC,
  // the open write request and the coil byte being packed.
  class modbus_frame_scoreboard;
    frame_t      frame_bytes_due[$];
    int          mismatches;
    logic [15:0] crc;
    logic [15:0] values_left;
    logic        collecting;
    kind_t       open_kind;
    logic [7:0]  coil_byte;
    logic [2:0]  coil_cnt;

    function new();
      mismatches  = 0;
      crc         = CRC_INIT;
      values_left = '0;
      collecting  = 1'b0;
      open_kind   = KIND_READ_COILS;
      coil_byte   = '0;
      coil_cnt    = '0;
    endfunction

    task report(string what);
      mismatches++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    function void push(logic [7:0] b, logic last, logic rej);
      frame_t f;
      f.tx_byte   = b;
      f.frame_end = last;
      f.rejected  = rej;
      frame_bytes_due.push_back(f);
    endfunction

    // A data byte goes into the CRC, LSB first, then into the frame.
    function void send(logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      crc = c;
      push(b, 1'b0, 1'b0);
    endfunction

    function void close_frame();
      push(crc[7:0], 1'b0, 1'b0);
      push(crc[15:8], 1'b1, 1'b0);
      crc         = CRC_INIT;
      collecting  = 1'b0;
      values_left = '0;
      coil_byte   = '0;
      coil_cnt    = '0;
    endfunction

    function void take_value(logic [15:0] v);
      if (open_kind == KIND_WRITE_COILS) begin
        if (v != 16'd0) begin
          coil_byte[coil_cnt] = 1'b1;
        end
        if (coil_cnt == 3'd7 || values_left == 16'd1) begin
          send(coil_byte);
          coil_byte = '0;
          coil_cnt  = '0;
        end else begin
          coil_cnt++;
        end
      end else begin
        send(v[15:8]);
        send(v[7:0]);
      end
      values_left--;
      if (values_left == 16'd0) begin
        close_frame();
      end
    endfunction

    function void note_item(item_t it);
      logic [16:0] coil_bytes;
      logic [7:0]  fc;
      if (collecting) begin
        take_value(it.value);
        return;
      end
      if ((it.func == KIND_WRITE_COILS && it.quantity > MAX_WRITE_COILS) ||
          (it.func == KIND_WRITE_REGS && it.quantity > MAX_WRITE_REGS)) begin
        push(8'h00, 1'b1, 1'b1);
        return;
      end
      case (it.func)
        KIND_READ_COILS:   fc = FC_READ_COILS;
        KIND_READ_HOLDING: fc = FC_READ_HOLDING;
        KIND_WRITE_COILS:  fc = FC_WRITE_COILS;
        default:           fc = FC_WRITE_REGS;
      endcase
      open_kind = it.func;
      crc       = CRC_INIT;
      coil_byte = '0;
      coil_cnt  = '0;
      send(it.slave_address);
      send(fc);
      send(it.start_address[15:8]);
      send(it.start_address[7:0]);
      send(it.quantity[15:8]);
      send(it.quantity[7:0]);
      if (it.func == KIND_READ_COILS || it.func == KIND_READ_HOLDING) begin
        close_frame();
        return;
      end
      coil_bytes = {1'b0, it.quantity} + 17'd7;
      send(it.func == KIND_WRITE_COILS ? coil_bytes[10:3] : {it.quantity[6:0], 1'b0});
      if (it.quantity == 16'd0) begin
        close_frame();
        return;
      end
      collecting  = 1'b1;
      values_left = it.quantity;
      take_value(it.value);
    endfunction

    task check_byte(frame_t got);
      frame_t want;
      if (frame_bytes_due.size() == 0) begin
        report($sformatf("unexpected byte %02h end %0b rej %0b",
                         got.tx_byte, got.frame_end, got.rejected));
        return;
      end
      want = frame_bytes_due.pop_front();
      if (got.tx_byte !== want.tx_byte) begin
        report($sformatf("tx_byte %02h, want %02h", got.tx_byte, want.tx_byte));
      end
      if (got.frame_end !== want.frame_end) begin
        report($sformatf("frame_end %0b, want %0b", got.frame_end, want.frame_end));
      end
      if (got.rejected !== want.rejected) begin
        report($sformatf("rejected %0b, want %0b", got.rejected, want.rejected));
      end
    endtask
  endclass

  // Cycles allowed after the last expected byte for work that yields no byte,
  // such as a coil that does not complete a byte.
  localparam int SETTLE_CYCLES = 20;

  logic   clk = 1'b0;
  logic   rst;
  logic   item_valid;
  logic   item_ready;
  item_t  item;
  logic   frame_valid;
  logic   frame_ready;
  frame_t frame;

  modbus_frame_scoreboard sb = new();

  int items_sent = 0;
  int burst_left = 0;

  always #10 clk = ~clk;

  modbus_rtu_request_framer u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  // Every frame transaction is checked at the edge where it completes.
  always @(posedge clk) begin
    if (!rst && frame_valid && frame_ready) begin
      sb.check_byte(frame);
    end
  end

  // The receiver switches among several back-pressure styles, each held for
  // a random span: always ready, coin flip, mostly stalled, and long runs of
  // either level.
  initial begin : receiver
    int mode;
    int span;
    frame_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: begin
            frame_ready <= 1'b1;
          end
          1: begin
            frame_ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            frame_ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            frame_ready <= ($urandom_range(0, 7) == 0) ? ~frame_ready : frame_ready;
          end
        endcase
      end
    end
  end

  // Coil values lean toward zero and all-ones so that both coil states and
  // the register extremes come up often.
  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Called at a falling edge. The sender works in bursts; when a burst runs
  // out, valid drops for a random gap so that it is never lowered and raised
  // within one time step. Returns at the falling edge after the transaction,
  // with valid still high unless the next call drops it.
  task automatic send_item(item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                : $urandom_range(1, 6);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Holds off the sender until every predicted byte has been delivered and
  // the block has had time to finish any byte-less work.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(negedge clk);
    while (sb.frame_bytes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One whole request: a header item with random slave, address and first
  // value, then one further item per remaining value for an accepted write.
  // The fields other than value in those follow-on items are random, as the
  // block must ignore them.
  task automatic send_request(kind_t k, logic [15:0] qty);
    item_t it;
    int    extra;
    it.func          = k;
    it.slave_address = 8'($urandom_range(0, 255));
    it.start_address = 16'($urandom_range(0, 65535));
    it.quantity      = qty;
    it.value         = rand_value();
    extra = 0;
    if (k == KIND_WRITE_COILS && qty != 16'd0 && qty <= MAX_WRITE_COILS) begin
      extra = qty - 1;
    end
    if (k == KIND_WRITE_REGS && qty != 16'd0 && qty <= MAX_WRITE_REGS) begin
      extra = qty - 1;
    end
    send_item(it);
    repeat (extra) begin
      it.func          = kind_t'($urandom_range(0, 3));
      it.slave_address = 8'($urandom_range(0, 255));
      it.start_address = 16'($urandom_range(0, 65535));
      it.quantity      = 16'($urandom_range(0, 65535));
      it.value         = rand_value();
      send_item(it);
    end
  endtask

  initial begin : stimulus
    item_t it;
    int    choice;

    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Reads at the field extremes, including a zero quantity
    // that is legal for a read, with values that must be ignored.
    it = '{func: KIND_READ_COILS, slave_address: 8'h00, start_address: 16'h0000,
           quantity: 16'h0000, value: 16'hFFFF};
    send_item(it);
    it = '{func: KIND_READ_HOLDING, slave_address: 8'hFF, start_address: 16'hFFFF,
           quantity: 16'hFFFF, value: 16'h0000};
    send_item(it);

    // Writes with a zero quantity close with byte count zero at once.
    send_request(KIND_WRITE_COILS, 16'd0);
    send_request(KIND_WRITE_REGS, 16'd0);

    // One past each write limit is rejected with a single marker transaction.
    send_request(KIND_WRITE_COILS, MAX_WRITE_COILS + 16'd1);
    send_request(KIND_WRITE_REGS, MAX_WRITE_REGS + 16'd1);

    // Nine coils fill one byte and leave a partial second byte.
    send_request(KIND_WRITE_COILS, 16'd9);

    // A register write whose second item looks like a read header: while the
    // write is open it must be taken as a plain value.
    it = '{func: KIND_WRITE_REGS, slave_address: 8'h5A, start_address: 16'h8001,
           quantity: 16'd2, value: 16'hFFFF};
    send_item(it);
    it = '{func: KIND_READ_COILS, slave_address: 8'hFF, start_address: 16'hFFFF,
           quantity: 16'hFFFF, value: 16'h0000};
    send_item(it);

    wait_drained();

    // Random part: mostly complete requests with random content, plus
    // oversized writes, zero-length writes and the odd long write.
    while (items_sent < 400) begin
      choice = $urandom_range(0, 19);
      if (choice <= 4) begin
        send_request(kind_t'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
      end else if (choice <= 9) begin
        send_request(KIND_WRITE_COILS, 16'($urandom_range(1, 24)));
      end else if (choice <= 14) begin
        send_request(KIND_WRITE_REGS, 16'($urandom_range(1, 8)));
      end else if (choice == 15) begin
        send_request(KIND_WRITE_COILS, 16'($urandom_range(MAX_WRITE_COILS + 1, 65535)));
      end else if (choice == 16) begin
        send_request(KIND_WRITE_REGS, 16'($urandom_range(MAX_WRITE_REGS + 1, 65535)));
      end else if (choice == 17) begin
        send_request(kind_t'($urandom_range(2, 3)), 16'd0);
      end else if (choice == 18) begin
        if ($urandom_range(0, 1) == 0) begin
          send_request(KIND_WRITE_REGS, MAX_WRITE_REGS);
        end else begin
          send_request(KIND_WRITE_COILS, 16'($urandom_range(25, 80)));
        end
      end else begin
        wait_drained();
      end
    end

    // Let the block empty out, then wait out the settle time in which any
    // stray transaction would still be caught.
    item_valid <= 1'b0;
    while (sb.frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.frame_bytes_due.size() != 0) begin
      sb.report($sformatf("%0d frame bytes never delivered", sb.frame_bytes_due.size()));
    end
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // A correct run needs well under a tenth of this.
  initial begin : watchdog
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
